### rtl/core/hsvled_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvled_pkg
// Shared types, constants and helpers of the HSV/RGB LED PWM bit encoder.
// ----------------------------------------------------------------------------
package hsvled_pkg;

  // bits sent per pixel and index width of the bit counter
  localparam int NumBits  = 24;
  localparam int CntWidth = $clog2(NumBits + 1);

  // hue arithmetic
  localparam int HueWrap   = 360;
  localparam int SectorDeg = 60;
  localparam int NumSect   = 6;
  // ceil(2^16 / 60), reciprocal used for the divide by sixty
  localparam int Recip60   = 1093;
  localparam int RecipShift = 16;

  // register reset values
  localparam logic [7:0] OneCodeRst  = 8'd57;
  localparam logic [7:0] ZeroCodeRst = 8'd28;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgColorMode = 2'd0,
    CfgOneCode   = 2'd1,
    CfgZeroCode  = 2'd2
  } cfg_idx_e;

  // configuration register set
  typedef struct packed {
    logic       color_mode;
    logic [7:0] one_code;
    logic [7:0] zero_code;
  } cfg_t;

  // green:red:blue word handed to the serializer
  typedef logic [NumBits-1:0] grb_t;

  // sector number of a hue already below 360
  function automatic logic [2:0] sector_of(logic [8:0] hh);
    logic [2:0] sec;
    sec = 3'd0;
    for (int k = 1; k < NumSect; k++) begin
      if (hh >= 9'(k * SectorDeg)) sec = 3'(k);
    end
    return sec;
  endfunction

  // first hue of a sector
  function automatic logic [8:0] sector_base(logic [2:0] sec);
    logic [8:0] base;
    base = 9'd0;
    for (int k = 1; k < NumSect; k++) begin
      if (sec == 3'(k)) base = 9'(k * SectorDeg);
    end
    return base;
  endfunction

endpackage

### rtl/core/hsvled_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvled_if
// Valid/ready channels: pixel requests in, PWM code requests out.
// ----------------------------------------------------------------------------
interface hsvled_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [8:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;

  modport source (
    output valid, red, green, blue, hue, saturation, brightness,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue, hue, saturation, brightness,
    output ready
  );
endinterface

interface hsvled_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] compare_value;
  logic       last;

  modport source (
    output valid, compare_value, last,
    input  ready
  );
  modport sink (
    input  valid, compare_value, last,
    output ready
  );
endinterface

### rtl/core/hsvled_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvled_convert
// Five stage pipeline turning an RGB or HSV pixel into a green:red:blue word.
// ----------------------------------------------------------------------------
module hsvled_convert (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hsvled_pkg::cfg_t    cfg_i,
  hsvled_pix_if.sink          pix,
  output logic                word_valid_o,
  input  logic                word_ready_i,
  output hsvled_pkg::grb_t    word_o
);

  typedef struct packed {
    logic             mode;
    hsvled_pkg::grb_t rgb;
    logic [7:0]       v;
    logic [2:0]       sector;
    logic [5:0]       angle;
    logic [15:0]      prod;
  } s1_t;

  typedef struct packed {
    logic             mode;
    hsvled_pkg::grb_t rgb;
    logic [7:0]       v;
    logic [2:0]       sector;
    logic [5:0]       angle;
    logic [7:0]       low;
  } s2_t;

  typedef struct packed {
    logic             mode;
    hsvled_pkg::grb_t rgb;
    logic [7:0]       v;
    logic [2:0]       sector;
    logic [7:0]       low;
    logic [13:0]      prod;
  } s3_t;

  typedef struct packed {
    logic             mode;
    hsvled_pkg::grb_t rgb;
    logic [7:0]       v;
    logic [2:0]       sector;
    logic [7:0]       low;
    logic [13:0]      prod;
    logic [8:0]       q0;
  } s4_t;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;
  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  hsvled_pkg::grb_t word_d, word_q;

  // stage advance, a stage moves when empty or when its successor moves
  assign en5 = !v5_q || word_ready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign pix.ready = en1;

  // stage 1: hue wrap, sector, angle and (255 - s) * v
  logic [8:0] hh;
  logic [5:0] rem;
  logic [8:0] rem_full;
  always_comb begin
    hh = (pix.hue >= 9'(hsvled_pkg::HueWrap)) ? pix.hue - 9'(hsvled_pkg::HueWrap) : pix.hue;
    s1_d.mode   = cfg_i.color_mode;
    s1_d.rgb    = {pix.green, pix.red, pix.blue};
    s1_d.v      = pix.brightness;
    s1_d.sector = hsvled_pkg::sector_of(hh);
    rem_full    = hh - hsvled_pkg::sector_base(s1_d.sector);
    rem         = rem_full[5:0];
    s1_d.angle  = s1_d.sector[0] ? 6'(hsvled_pkg::SectorDeg) - rem : rem;
    s1_d.prod   = {8'd0, 8'hFF - pix.saturation} * {8'd0, pix.brightness};
  end

  // stage 2: low = prod / 255, exact for any 8 bit by 8 bit product
  logic [15:0] div_sum;
  always_comb begin
    div_sum     = s1_q.prod + {8'd0, s1_q.prod[15:8]} + 16'd1;
    s2_d.mode   = s1_q.mode;
    s2_d.rgb    = s1_q.rgb;
    s2_d.v      = s1_q.v;
    s2_d.sector = s1_q.sector;
    s2_d.angle  = s1_q.angle;
    s2_d.low    = div_sum[15:8];
  end

  // stage 3: (high - low) * angle
  logic [7:0] diff;
  always_comb begin
    diff        = s2_q.v - s2_q.low;
    s3_d.mode   = s2_q.mode;
    s3_d.rgb    = s2_q.rgb;
    s3_d.v      = s2_q.v;
    s3_d.sector = s2_q.sector;
    s3_d.low    = s2_q.low;
    s3_d.prod   = {6'd0, diff} * {8'd0, s2_q.angle};
  end

  // stage 4: reciprocal estimate of prod / 60, at most one too high
  logic [24:0] recip;
  always_comb begin
    recip       = {11'd0, s3_q.prod} * 25'(hsvled_pkg::Recip60);
    s4_d.mode   = s3_q.mode;
    s4_d.rgb    = s3_q.rgb;
    s4_d.v      = s3_q.v;
    s4_d.sector = s3_q.sector;
    s4_d.low    = s3_q.low;
    s4_d.prod   = s3_q.prod;
    s4_d.q0     = recip[hsvled_pkg::RecipShift +: 9];
  end

  // stage 5: quotient correction, middle value and sector mapping
  logic [14:0] chk;
  logic [8:0]  q_full;
  logic [7:0]  mid, hi, lo;
  always_comb begin
    chk    = {6'd0, s4_q.q0} * 15'(hsvled_pkg::SectorDeg);
    q_full = (chk > {1'b0, s4_q.prod}) ? s4_q.q0 - 9'd1 : s4_q.q0;
    hi     = s4_q.v;
    lo     = s4_q.low;
    mid    = lo + q_full[7:0];
    case (s4_q.sector)
      3'd0:    word_d = {mid, hi,  lo };
      3'd1:    word_d = {hi,  mid, lo };
      3'd2:    word_d = {hi,  lo,  mid};
      3'd3:    word_d = {mid, lo,  hi };
      3'd4:    word_d = {lo,  mid, hi };
      default: word_d = {lo,  hi,  mid};
    endcase
    if (!s4_q.mode) word_d = s4_q.rgb;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pix.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) s3_q <= s3_d;
    if (en4) s4_q <= s4_d;
    if (en5) word_q <= word_d;
  end

  assign word_valid_o = v5_q;
  assign word_o       = word_q;

  // a stalled word stays put
  a_word_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && !word_ready_i) |=> (v5_q && $stable(word_q)))
    else $error("converter output changed while stalled");

  // the middle value never passes the high value in hsv mode
  a_mid_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && s4_q.mode) |-> ({1'b0, mid} <= {1'b0, hi}))
    else $error("middle value above high value");

  // the divide estimate is never low and at most one high; only the upper bound is checked
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> ({6'd0, s4_q.q0} * 15'(hsvled_pkg::SectorDeg) <=
              {1'b0, s4_q.prod} + 15'(hsvled_pkg::SectorDeg)))
    else $error("reciprocal quotient out of range");

endmodule

### rtl/core/hsvled_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvled_serializer
// Shifts a green:red:blue word out as one PWM compare code per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module hsvled_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hsvled_pkg::cfg_t    cfg_i,
  input  logic                word_valid_i,
  output logic                word_ready_o,
  input  hsvled_pkg::grb_t    word_i,
  hsvled_code_if.source       code
);

  localparam logic [hsvled_pkg::CntWidth-1:0] LastCnt =
    hsvled_pkg::CntWidth'(hsvled_pkg::NumBits - 1);
  localparam logic [hsvled_pkg::CntWidth-1:0] CntOne =
    hsvled_pkg::CntWidth'(1);

  logic                            busy_q;
  logic [hsvled_pkg::CntWidth-1:0] cnt_q;
  hsvled_pkg::grb_t                word_q;
  logic                            at_last;
  logic                            code_take;
  logic                            load;

  assign at_last      = (cnt_q == LastCnt);
  assign code_take    = code.valid && code.ready;
  assign word_ready_o = !busy_q || (code.ready && at_last);
  assign load         = word_valid_i && word_ready_o;

  // counter and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (code_take) begin
      busy_q <= !at_last;
      cnt_q  <= at_last ? '0 : cnt_q + CntOne;
    end
  end

  // shift register, msb first
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_i;
    end else if (code_take) begin
      word_q <= {word_q[hsvled_pkg::NumBits-2:0], 1'b0};
    end
  end

  // code request
  assign code.valid         = busy_q;
  assign code.compare_value = word_q[hsvled_pkg::NumBits-1] ? cfg_i.one_code
                                                            : cfg_i.zero_code;
  assign code.last          = busy_q && at_last;

  // counter stays inside the word while busy
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q <= LastCnt))
    else $error("bit counter past end of word");

  // after the last code the counter restarts
  a_last_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (code_take && code.last) |=> (cnt_q == '0))
    else $error("counter did not restart after last code");

  // no new word is taken in the middle of a pixel
  a_no_midword_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !at_last) |-> !word_ready_o)
    else $error("word taken before pixel finished");

endmodule

### rtl/core/hsv_rgb_led_pwm_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_rgb_led_pwm_encoder
// Converts RGB or HSV pixels into 24 LED PWM compare codes, green first.
// ----------------------------------------------------------------------------
//  channel  direction  payload                                     handshake
//  pix_i    in         red green blue hue saturation brightness    valid/ready
//  code_o   out        compare_value last                          valid/ready
//  cfg      in         cfg_idx_i cfg_wdata_i                       cfg_we_i
//
//  The serializer sends a pixel's 24 codes, one code per cycle while code_o is ready.
//  A taken pixel request passes five converter register stages plus the serializer
//  load before its first code is valid.
//  A new pixel enters the pipeline every cycle until the serializer backs up.
//  Reset clears valid bits, busy flag and counter, and sets the config registers (one 57, zero 28, RGB mode).
//  A stall on code_o holds every occupied stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module hsv_rgb_led_pwm_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsvled_pix_if.sink     pix_i,
  hsvled_code_if.source  code_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  hsvled_pkg::cfg_t cfg_q;
  logic             word_valid;
  logic             word_ready;
  hsvled_pkg::grb_t word;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_mode <= 1'b0;
      cfg_q.one_code   <= hsvled_pkg::OneCodeRst;
      cfg_q.zero_code  <= hsvled_pkg::ZeroCodeRst;
    end else if (cfg_we_i) begin
      case (hsvled_pkg::cfg_idx_e'(cfg_idx_i))
        hsvled_pkg::CfgColorMode: cfg_q.color_mode <= cfg_wdata_i[0];
        hsvled_pkg::CfgOneCode:   cfg_q.one_code   <= cfg_wdata_i;
        hsvled_pkg::CfgZeroCode:  cfg_q.zero_code  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // color conversion pipeline
  hsvled_convert u_convert (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pix          (pix_i),
    .word_valid_o (word_valid),
    .word_ready_i (word_ready),
    .word_o       (word)
  );

  // bit serializer
  hsvled_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .word_valid_i (word_valid),
    .word_ready_o (word_ready),
    .word_i       (word),
    .code         (code_o)
  );

endmodule

### tb/tb_hsv_rgb_led_pwm_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hsv_rgb_led_pwm_encoder
// Sends RGB and HSV pixel requests through the encoder and checks every PWM
// code request against an in-bench color predictor. Directed corner cases run
// first, then randomized pixels under several register settings, with random
// backpressure on both channels in two of the three runs.
// ----------------------------------------------------------------------------
module tb_hsv_rgb_led_pwm_encoder;

  localparam int         ClkHalf      = 6;
  localparam int         SettleCycles = 8;
  localparam int         DrainCycles  = 20;
  localparam int         ShowLimit    = 10;
  localparam int         ChunkItems   = 20;
  localparam logic [1:0] CfgUnmapped  = 2'd3;
  localparam logic       ModeRgb      = 1'b0;
  localparam logic       ModeHsv      = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } pixel_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } pwm_code_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_wdata;

  hsvled_pix_if  pix_if ();
  hsvled_code_if code_if ();

  hsv_rgb_led_pwm_encoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .pix_i       (pix_if),
    .code_o      (code_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // register shadow and expected code requests
  logic       cur_mode;
  logic [7:0] cur_one_code;
  logic [7:0] cur_zero_code;
  pwm_code_t  expected_codes[$];
  int         mismatch_count;
  int         src_idle_pct;
  int         snk_idle_pct;

  // clock
  initial begin
    clk = 1'b0;
    forever #(ClkHalf) clk = ~clk;
  end

  // receiver backpressure
  initial begin
    code_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      code_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // hsv to green:red:blue, six-sector integer arithmetic
  function automatic hsvled_pkg::grb_t convert_hsv(logic [8:0] h, logic [7:0] s,
                                                   logic [7:0] v);
    int unsigned hh, sect, rem, angle, lo, mid, hi;
    int unsigned r, g, b;
    hh    = h % 360;
    sect  = hh / 60;
    rem   = hh % 60;
    angle = sect[0] ? (60 - rem) : rem;
    hi    = v;
    lo    = ((255 - s) * hi) / 255;
    mid   = lo + ((hi - lo) * angle) / 60;
    if (v == 0) begin
      r = 0; g = 0; b = 0;
    end else if (s == 0) begin
      r = v; g = v; b = v;
    end else begin
      case (sect)
        0: begin r = hi;  g = mid; b = lo;  end
        1: begin r = mid; g = hi;  b = lo;  end
        2: begin r = lo;  g = hi;  b = mid; end
        3: begin r = lo;  g = mid; b = hi;  end
        4: begin r = mid; g = lo;  b = hi;  end
        default: begin r = hi; g = lo; b = mid; end
      endcase
    end
    return {g[7:0], r[7:0], b[7:0]};
  endfunction

  // expected code sequence of one pixel, green msb first
  function automatic void predict_codes(pixel_t px);
    hsvled_pkg::grb_t word;
    pwm_code_t        c;
    if (cur_mode == ModeHsv) word = convert_hsv(px.hue, px.saturation, px.brightness);
    else word = {px.green, px.red, px.blue};
    for (int k = 0; k < hsvled_pkg::NumBits; k++) begin
      c.value = word[hsvled_pkg::NumBits-1-k] ? cur_one_code : cur_zero_code;
      c.last  = (k == hsvled_pkg::NumBits - 1);
      expected_codes.push_back(c);
    end
  endfunction

  function automatic pixel_t rgb_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_t px;
    px.red        = r;
    px.green      = g;
    px.blue       = b;
    px.hue        = 9'($urandom_range(511));
    px.saturation = 8'($urandom);
    px.brightness = 8'($urandom);
    return px;
  endfunction

  function automatic pixel_t hsv_pixel(logic [8:0] h, logic [7:0] s, logic [7:0] v);
    pixel_t px;
    px.red        = 8'($urandom);
    px.green      = 8'($urandom);
    px.blue       = 8'($urandom);
    px.hue        = h;
    px.saturation = s;
    px.brightness = v;
    return px;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= ShowLimit) $display("%0t: %s", $realtime, msg);
  endtask

  // one pixel request, with random idle cycles ahead of it
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      pix_if.valid <= 1'b0;
    end
    @(negedge clk);
    pix_if.valid      <= 1'b1;
    pix_if.red        <= px.red;
    pix_if.green      <= px.green;
    pix_if.blue       <= px.blue;
    pix_if.hue        <= px.hue;
    pix_if.saturation <= px.saturation;
    pix_if.brightness <= px.brightness;
    do @(posedge clk); while (!pix_if.ready);
    predict_codes(px);
  endtask

  // stop sending and let every expected code come out
  task automatic drain;
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      hsvled_pkg::CfgColorMode: cur_mode      = data[0];
      hsvled_pkg::CfgOneCode:   cur_one_code  = data;
      hsvled_pkg::CfgZeroCode:  cur_zero_code = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic mode, input logic [7:0] one, input logic [7:0] zero);
    drain();
    write_reg(hsvled_pkg::CfgColorMode, {7'($urandom), mode});
    write_reg(hsvled_pkg::CfgOneCode, one);
    write_reg(hsvled_pkg::CfgZeroCode, zero);
  endtask

  // code request checker
  always @(posedge clk) begin
    pwm_code_t want;
    if (rst_n && code_if.valid && code_if.ready) begin
      if (expected_codes.size() == 0) begin
        note_mismatch($sformatf("unexpected code value=%0d last=%0b",
                                code_if.compare_value, code_if.last));
      end else begin
        want = expected_codes.pop_front();
        if (code_if.compare_value !== want.value || code_if.last !== want.last)
          note_mismatch($sformatf("code expected value=%0d last=%0b, got value=%0d last=%0b",
                                  want.value, want.last, code_if.compare_value,
                                  code_if.last));
      end
    end
  end

  // reset register values, rgb extremes and single channels
  task automatic test_rgb_reset_codes;
    send_pixel(rgb_pixel(8'h00, 8'h00, 8'h00));
    send_pixel(rgb_pixel(8'hFF, 8'hFF, 8'hFF));
    send_pixel(rgb_pixel(8'hFF, 8'h00, 8'h00));
    send_pixel(rgb_pixel(8'h00, 8'hFF, 8'h00));
    send_pixel(rgb_pixel(8'h00, 8'h00, 8'hFF));
    send_pixel(rgb_pixel(8'hAA, 8'h55, 8'h81));
  endtask

  // code registers at their extremes
  task automatic test_code_extremes;
    configure(ModeRgb, 8'hFF, 8'h00);
    send_pixel(rgb_pixel(8'h5A, 8'hC3, 8'h0F));
    configure(ModeRgb, 8'h00, 8'hFF);
    send_pixel(rgb_pixel(8'h5A, 8'hC3, 8'h0F));
  endtask

  // a write to an unmapped index changes nothing
  task automatic test_unmapped_index;
    drain();
    write_reg(CfgUnmapped, 8'hFF);
    send_pixel(rgb_pixel(8'h96, 8'h69, 8'h3C));
  endtask

  // hsv: black, grey, every sector, hue wrap, unused rgb fields
  task automatic test_hsv_cases;
    configure(ModeHsv, hsvled_pkg::OneCodeRst, hsvled_pkg::ZeroCodeRst);
    send_pixel(hsv_pixel(9'd200, 8'd255, 8'd0));
    send_pixel(hsv_pixel(9'd77, 8'd0, 8'd200));
    send_pixel(hsv_pixel(9'd0, 8'd255, 8'd255));
    send_pixel(hsv_pixel(9'd59, 8'd255, 8'd255));
    send_pixel(hsv_pixel(9'd60, 8'd200, 8'd255));
    send_pixel(hsv_pixel(9'd119, 8'd128, 8'd180));
    send_pixel(hsv_pixel(9'd150, 8'd1, 8'd255));
    send_pixel(hsv_pixel(9'd210, 8'd255, 8'd1));
    send_pixel(hsv_pixel(9'd270, 8'd90, 8'd128));
    send_pixel(hsv_pixel(9'd359, 8'd255, 8'd255));
    send_pixel(hsv_pixel(9'd360, 8'd255, 8'd255));
    send_pixel(hsv_pixel(9'd511, 8'd170, 8'd240));
  endtask

  function automatic logic [7:0] pick_code;
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // random pixels in chunks, each chunk under a fresh register setting
  task automatic test_random_pixels(input int n_items, input int src_pct, input int snk_pct);
    pixel_t px;
    int     sent;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      configure(1'($urandom), pick_code(), pick_code());
      for (int i = 0; i < ChunkItems && sent < n_items; i++) begin
        px.red        = 8'($urandom);
        px.green      = 8'($urandom);
        px.blue       = 8'($urandom);
        px.hue        = ($urandom_range(7) == 0) ? 9'($urandom_range(511, 360))
                                                 : 9'($urandom_range(359));
        px.saturation = ($urandom_range(15) == 0) ? 8'd0 : 8'($urandom);
        px.brightness = ($urandom_range(15) == 0) ? 8'd0 : 8'($urandom);
        send_pixel(px);
        sent++;
      end
    end
  endtask

  // run limit
  initial begin
    #5_000_000;
    $display("hsv_rgb_led_pwm_encoder: mismatch");
    $finish;
  end

  // test sequence
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = hsvled_pkg::CfgColorMode;
    cfg_wdata         = 8'h00;
    pix_if.valid      = 1'b0;
    pix_if.red        = 8'h00;
    pix_if.green      = 8'h00;
    pix_if.blue       = 8'h00;
    pix_if.hue        = 9'h000;
    pix_if.saturation = 8'h00;
    pix_if.brightness = 8'h00;
    cur_mode          = ModeRgb;
    cur_one_code      = hsvled_pkg::OneCodeRst;
    cur_zero_code     = hsvled_pkg::ZeroCodeRst;
    mismatch_count    = 0;
    src_idle_pct      = 26;
    snk_idle_pct      = 71;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_rgb_reset_codes();
    test_code_extremes();
    test_unmapped_index();
    test_hsv_cases();
    test_random_pixels(146, 26, 71);
    test_random_pixels(146, 71, 26);
    test_random_pixels(147, 0, 0);

    drain();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_codes.size() == 0) begin
      $display("hsv_rgb_led_pwm_encoder: match");
    end else begin
      $display("hsv_rgb_led_pwm_encoder: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/hsvled_pkg.sv
rtl/core/hsvled_if.sv
rtl/core/hsvled_convert.sv
rtl/core/hsvled_serializer.sv
rtl/core/hsv_rgb_led_pwm_encoder.sv
tb/tb_hsv_rgb_led_pwm_encoder.sv
